>>> rtl/bcomp_pkg.sv
// shared types and constants for the barometric compensation block
`timescale 1ns / 1ps
`default_nettype none

package bcomp_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 2'd3;

    localparam logic signed [32:0] PRESS_T_OFFSET = 33'sd128000;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [20:0] PRESS_FULL = 21'd1048576;
    localparam logic signed [63:0] PRESS_BIAS = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coeffs;

    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] fine;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/bcomp_cfg.sv
// calibration coefficient registers
`timescale 1ns / 1ps
`default_nettype none

module bcomp_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [bcomp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bcomp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                    o_cfg_ready,
    output bcomp_pkg::t_coeffs                      o_coef
);

    logic [47:0] r_temp;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_p9   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bcomp_pkg::CFG_TEMP_COEFFS: r_temp <= i_cfg_data[47:0];
                bcomp_pkg::CFG_PRESS_A:     r_pa   <= i_cfg_data;
                bcomp_pkg::CFG_PRESS_B:     r_pb   <= i_cfg_data;
                bcomp_pkg::CFG_PRESS_LAST:  r_p9   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_coef.t1 = r_temp[15:0];
        o_coef.t2 = r_temp[31:16];
        o_coef.t3 = r_temp[47:32];
        o_coef.p1 = r_pa[15:0];
        o_coef.p2 = r_pa[31:16];
        o_coef.p3 = r_pa[47:32];
        o_coef.p4 = r_pa[63:48];
        o_coef.p5 = r_pb[15:0];
        o_coef.p6 = r_pb[31:16];
        o_coef.p7 = r_pb[47:32];
        o_coef.p8 = r_pb[63:48];
        o_coef.p9 = r_p9;
    end

endmodule

`default_nettype wire

>>> rtl/bcomp_temp.sv
// four-stage temperature compensation pipeline
`timescale 1ns / 1ps
`default_nettype none

module bcomp_temp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [19:0]        i_adt,
    input  wire logic [19:0]        i_adp,
    input  wire bcomp_pkg::t_coeffs i_coef,
    output logic                    o_vld,
    output logic [19:0]             o_adp,
    output bcomp_pkg::t_item        o_item
);

    logic signed [17:0] w_x;
    logic signed [16:0] w_d;
    logic signed [33:0] n_xt2;
    logic signed [33:0] n_dd;
    logic signed [31:0] w_dds;
    logic signed [47:0] n_m3;

    logic               r_vld1, r_vld2, r_vld3, r_vld4;
    logic [19:0]        r_adp1, r_adp2, r_adp3, r_adp4;
    logic signed [33:0] r_xt2;
    logic signed [33:0] r_dd;
    logic signed [31:0] r_a;
    logic signed [31:0] r_m3;
    logic signed [31:0] r_fine3;
    logic signed [31:0] r_fine4;
    logic signed [31:0] r_tc;

    assign w_x   = $signed({1'b0, i_adt[19:3]}) - $signed({1'b0, i_coef.t1, 1'b0});
    assign w_d   = $signed({1'b0, i_adt[19:4]}) - $signed({1'b0, i_coef.t1});
    assign n_xt2 = w_x * i_coef.t2;
    assign n_dd  = w_d * w_d;
    assign w_dds = $signed(r_dd[31:0]) >>> 12;
    assign n_m3  = w_dds * i_coef.t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adp1  <= i_adp;
        r_xt2   <= n_xt2;
        r_dd    <= n_dd;
        r_adp2  <= r_adp1;
        r_a     <= $signed(r_xt2[31:0]) >>> 11;
        r_m3    <= n_m3[31:0];
        r_adp3  <= r_adp2;
        r_fine3 <= r_a + (r_m3 >>> 14);
        r_adp4  <= r_adp3;
        r_fine4 <= r_fine3;
        r_tc    <= (r_fine3 + (r_fine3 <<< 2) + 32'sd128) >>> 8;
    end

    assign o_vld       = r_vld4;
    assign o_adp       = r_adp4;
    assign o_item.tc   = r_tc;
    assign o_item.fine = r_fine4;

endmodule

`default_nettype wire

>>> rtl/bcomp_pfront.sv
// pressure pipeline up to the dividend and divisor
`timescale 1ns / 1ps
`default_nettype none

module bcomp_pfront (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [19:0]        i_adp,
    input  wire bcomp_pkg::t_item   i_item,
    input  wire bcomp_pkg::t_coeffs i_coef,
    output logic                    o_vld,
    output logic [63:0]             o_num,
    output logic signed [63:0]      o_den,
    output bcomp_pkg::t_item        o_item
);

    logic [7:0]              r_vld;
    bcomp_pkg::t_item        r_item [0:7];
    logic [19:0]             r_adp [0:4];

    logic signed [32:0]      r_v1;
    logic signed [65:0]      n_sq;
    logic [62:0]             r_sq;
    logic signed [48:0]      n_v1p5, n_v1p2;
    logic signed [48:0]      r_v1p5_2, r_v1p5_3, r_v1p5_4;
    logic signed [48:0]      r_v1p2_2, r_v1p2_3, r_v1p2_4;
    logic signed [48:0]      n_l6, n_l3, n_h6, n_h3;
    logic signed [48:0]      r_l6, r_l3;
    logic [31:0]             r_h6, r_h3;
    logic signed [63:0]      r_prod6, r_prod3;
    logic signed [63:0]      r_v2, r_w;
    logic [47:0]             n_wl, n_wh;
    logic [47:0]             r_wl;
    logic [31:0]             r_wh;
    logic [20:0]             w_p;
    logic [63:0]             r_num0;
    logic signed [63:0]      w_wsum;
    logic signed [63:0]      r_v1f7, r_v1f8;
    logic [43:0]             n_nl, n_nh;
    logic [43:0]             r_nl;
    logic [31:0]             r_nh;
    logic [63:0]             r_num;

    assign n_sq   = r_v1 * r_v1;
    assign n_v1p5 = r_v1 * i_coef.p5;
    assign n_v1p2 = r_v1 * i_coef.p2;
    assign n_l6   = $signed({1'b0, r_sq[31:0]}) * i_coef.p6;
    assign n_h6   = $signed({2'b0, r_sq[62:32]}) * i_coef.p6;
    assign n_l3   = $signed({1'b0, r_sq[31:0]}) * i_coef.p3;
    assign n_h3   = $signed({2'b0, r_sq[62:32]}) * i_coef.p3;
    assign n_wl   = r_w[31:0] * i_coef.p1;
    assign n_wh   = r_w[63:32] * i_coef.p1;
    assign w_p    = bcomp_pkg::PRESS_FULL - {1'b0, r_adp[4]};
    assign w_wsum = {r_wh, 32'd0} + 64'(r_wl);
    assign n_nl   = r_num0[31:0] * bcomp_pkg::PRESS_SCALE;
    assign n_nh   = r_num0[63:32] * bcomp_pkg::PRESS_SCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        r_adp[0]  <= i_adp;
        for (int k = 1; k < 8; k++) begin
            r_item[k] <= r_item[k-1];
        end
        for (int k = 1; k < 5; k++) begin
            r_adp[k] <= r_adp[k-1];
        end
        // stage 1
        r_v1     <= 33'(i_item.fine) - bcomp_pkg::PRESS_T_OFFSET;
        // stage 2
        r_sq     <= n_sq[62:0];
        r_v1p5_2 <= n_v1p5;
        r_v1p2_2 <= n_v1p2;
        // stage 3
        r_l6     <= n_l6;
        r_h6     <= n_h6[31:0];
        r_l3     <= n_l3;
        r_h3     <= n_h3[31:0];
        r_v1p5_3 <= r_v1p5_2;
        r_v1p2_3 <= r_v1p2_2;
        // stage 4
        r_prod6  <= 64'(r_l6) + {r_h6, 32'd0};
        r_prod3  <= 64'(r_l3) + {r_h3, 32'd0};
        r_v1p5_4 <= r_v1p5_3;
        r_v1p2_4 <= r_v1p2_3;
        // stage 5
        r_v2     <= r_prod6 + (64'(r_v1p5_4) <<< 17) + (64'(i_coef.p4) <<< 35);
        r_w      <= bcomp_pkg::PRESS_BIAS + (r_prod3 >>> 8) + (64'(r_v1p2_4) <<< 12);
        // stage 6
        r_wl     <= n_wl;
        r_wh     <= n_wh[31:0];
        r_num0   <= (64'(w_p) << 31) - r_v2;
        // stage 7
        r_v1f7   <= w_wsum >>> 33;
        r_nl     <= n_nl;
        r_nh     <= n_nh[31:0];
        // stage 8
        r_v1f8   <= r_v1f7;
        r_num    <= {r_nh, 32'd0} + 64'(r_nl);
    end

    assign o_vld  = r_vld[7];
    assign o_num  = r_num;
    assign o_den  = r_v1f8;
    assign o_item = r_item[7];

endmodule

`default_nettype wire

>>> rtl/bcomp_div.sv
// pipelined signed 64-bit divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module bcomp_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vld,
    input  wire logic [63:0]            i_num,
    input  wire logic signed [63:0]     i_den,
    input  wire bcomp_pkg::t_item       i_item,
    output logic                        o_vld,
    output logic [63:0]                 o_quo,
    output logic                        o_neg,
    output logic                        o_zero,
    output bcomp_pkg::t_item            o_item
);

    localparam int N = bcomp_pkg::DIV_W;

    logic [N:0]             r_vld;
    logic [63:0]            r_rem  [0:N];
    logic [63:0]            r_nq   [0:N];
    logic [63:0]            r_md   [0:N];
    logic                   r_neg  [0:N];
    logic                   r_zero [0:N];
    bcomp_pkg::t_item       r_item [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    // magnitudes and sign
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_nq[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
        r_md[0]   <= i_den[63] ? 64'd0 - i_den : i_den;
        r_neg[0]  <= i_num[63] ^ i_den[63];
        r_zero[0] <= (i_den == 64'sd0);
        r_item[0] <= i_item;
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [63:0] w_rs;
        logic [63:0] w_diff;
        logic        w_ge;

        assign w_rs   = {r_rem[g][62:0], r_nq[g][63]};
        assign w_ge   = (w_rs >= r_md[g]);
        assign w_diff = w_rs - r_md[g];

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= w_ge ? w_diff : w_rs;
            r_nq[g+1]   <= {r_nq[g][62:0], w_ge};
            r_md[g+1]   <= r_md[g];
            r_neg[g+1]  <= r_neg[g];
            r_zero[g+1] <= r_zero[g];
            r_item[g+1] <= r_item[g];
        end
    end

    assign o_vld  = r_vld[N];
    assign o_quo  = r_nq[N];
    assign o_neg  = r_neg[N];
    assign o_zero = r_zero[N];
    assign o_item = r_item[N];

endmodule

`default_nettype wire

>>> rtl/bcomp_pback.sv
// pressure pipeline after the divider, with output registers
`timescale 1ns / 1ps
`default_nettype none

module bcomp_pback (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [63:0]        i_quo,
    input  wire logic               i_neg,
    input  wire logic               i_zero,
    input  wire bcomp_pkg::t_item   i_item,
    input  wire bcomp_pkg::t_coeffs i_coef,
    output logic                    o_strobe,
    output bcomp_pkg::t_item        o_item,
    output logic [31:0]             o_press,
    output logic                    o_invalid
);

    logic [6:0]             r_vld;
    bcomp_pkg::t_item       r_item [0:5];
    logic                   r_zero [0:5];
    logic signed [63:0]     r_p [0:4];

    logic signed [48:0]     n_p8l, n_p8h, n_p9l, n_p9h;
    logic signed [48:0]     r_p8l, r_p9l;
    logic [31:0]            r_p8h, r_p9h;
    logic signed [63:0]     w_ps;
    logic signed [63:0]     r_ps2, r_ps3;
    logic signed [63:0]     w_p8p;
    logic signed [63:0]     r_w2_3, r_w2_4, r_w2_5;
    logic signed [63:0]     r_m9;
    logic [63:0]            n_ll, n_lh, n_hl;
    logic [63:0]            r_ll;
    logic [31:0]            r_lh, r_hl;
    logic signed [63:0]     w_m;
    logic signed [63:0]     r_w1;
    logic signed [63:0]     r_s;
    logic signed [63:0]     w_res;
    bcomp_pkg::t_item       r_oitem;
    logic [31:0]            r_press;
    logic                   r_invalid;

    assign w_ps  = r_p[0] >>> 13;
    assign n_p8l = $signed({1'b0, r_p[0][31:0]}) * i_coef.p8;
    assign n_p8h = $signed({1'b0, r_p[0][63:32]}) * i_coef.p8;
    assign n_p9l = $signed({1'b0, w_ps[31:0]}) * i_coef.p9;
    assign n_p9h = $signed({1'b0, w_ps[63:32]}) * i_coef.p9;
    assign w_p8p = 64'(r_p8l) + {r_p8h, 32'd0};
    assign n_ll  = r_m9[31:0] * r_ps3[31:0];
    assign n_lh  = r_m9[31:0] * r_ps3[63:32];
    assign n_hl  = r_m9[63:32] * r_ps3[31:0];
    assign w_m   = r_ll + {r_lh + r_hl, 32'd0};
    assign w_res = (r_s >>> 8) + (64'(i_coef.p7) <<< 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        r_zero[0] <= i_zero;
        for (int k = 1; k < 6; k++) begin
            r_item[k] <= r_item[k-1];
            r_zero[k] <= r_zero[k-1];
        end
        for (int k = 1; k < 5; k++) begin
            r_p[k] <= r_p[k-1];
        end
        // stage 1: restore quotient sign
        r_p[0]    <= i_neg ? 64'sd0 - $signed(i_quo) : $signed(i_quo);
        // stage 2
        r_p8l     <= n_p8l;
        r_p8h     <= n_p8h[31:0];
        r_p9l     <= n_p9l;
        r_p9h     <= n_p9h[31:0];
        r_ps2     <= w_ps;
        // stage 3
        r_w2_3    <= w_p8p >>> 19;
        r_m9      <= 64'(r_p9l) + {r_p9h, 32'd0};
        r_ps3     <= r_ps2;
        // stage 4
        r_ll      <= n_ll;
        r_lh      <= n_lh[31:0];
        r_hl      <= n_hl[31:0];
        r_w2_4    <= r_w2_3;
        // stage 5
        r_w1      <= w_m >>> 25;
        r_w2_5    <= r_w2_4;
        // stage 6
        r_s       <= r_p[4] + r_w1 + r_w2_5;
        // stage 7: output word
        r_oitem   <= r_item[5];
        r_invalid <= r_zero[5];
        r_press   <= r_zero[5] ? 32'd0 : w_res[31:0];
    end

    assign o_strobe  = r_vld[6];
    assign o_item    = r_oitem;
    assign o_press   = r_press;
    assign o_invalid = r_invalid;

endmodule

`default_nettype wire

>>> rtl/baro_temp_pressure_compensation.sv
// top level of the barometric temperature and pressure compensation block
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Load the calibration words over the cfg channel (index 0 temperature
// coefficients, 1 and 2 pressure coefficient groups, 3 the last pressure
// coefficient); cfg_ready is always high, so a write lands at any edge with
// cfg_valid high. Write coefficients only while no word is in flight.
// Present raw temperature and raw pressure with start high; busy is always
// low, so a new word is taken every cycle.
// Each word comes out on o_strobe for one cycle, with compensated
// temperature, fine temperature, pressure and the invalid flag. The
// pipeline runs through the 64-stage divider, one quotient bit per stage,
// plus the multiplier stages around it; throughput is one word per cycle.
// A zero pressure divisor gives pressure 0 with the invalid flag set.
// Synchronous reset clears all coefficients and drops every word in flight.
// The receiver cannot stall; results are never held back.

module baro_temp_pressure_compensation (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [19:0]                        i_raw_temperature,
    input  wire logic [19:0]                        i_raw_pressure,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bcomp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bcomp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                    o_strobe,
    output logic signed [31:0]                      o_temperature_centi,
    output logic signed [31:0]                      o_fine_temperature,
    output logic [31:0]                             o_pressure_q24_8,
    output logic                                    o_pressure_invalid
);

    bcomp_pkg::t_coeffs     w_coef;
    logic                   w_t_vld;
    logic [19:0]            w_t_adp;
    bcomp_pkg::t_item       w_t_item;
    logic                   w_f_vld;
    logic [63:0]            w_f_num;
    logic signed [63:0]     w_f_den;
    bcomp_pkg::t_item       w_f_item;
    logic                   w_d_vld;
    logic [63:0]            w_d_quo;
    logic                   w_d_neg;
    logic                   w_d_zero;
    bcomp_pkg::t_item       w_d_item;
    bcomp_pkg::t_item       w_o_item;

    assign busy = 1'b0;

    bcomp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coef      (w_coef)
    );

    bcomp_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_adt   (i_raw_temperature),
        .i_adp   (i_raw_pressure),
        .i_coef  (w_coef),
        .o_vld   (w_t_vld),
        .o_adp   (w_t_adp),
        .o_item  (w_t_item)
    );

    bcomp_pfront u_pfront (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_t_vld),
        .i_adp   (w_t_adp),
        .i_item  (w_t_item),
        .i_coef  (w_coef),
        .o_vld   (w_f_vld),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_item  (w_f_item)
    );

    bcomp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_item  (w_f_item),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_neg   (w_d_neg),
        .o_zero  (w_d_zero),
        .o_item  (w_d_item)
    );

    bcomp_pback u_pback (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_d_vld),
        .i_quo     (w_d_quo),
        .i_neg     (w_d_neg),
        .i_zero    (w_d_zero),
        .i_item    (w_d_item),
        .i_coef    (w_coef),
        .o_strobe  (o_strobe),
        .o_item    (w_o_item),
        .o_press   (o_pressure_q24_8),
        .o_invalid (o_pressure_invalid)
    );

    assign o_temperature_centi = w_o_item.tc;
    assign o_fine_temperature  = w_o_item.fine;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the barometric temperature and pressure compensation block
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_WORDS = 200;
    localparam int N_ROWS = 14;
    localparam int N_TYPED = 6;

    typedef struct {
        logic signed [31:0] tc;
        logic signed [31:0] fine;
        logic [31:0]        press;
        logic               inv;
    } t_reading;

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        bit          typed;
        t_reading    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [bcomp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bcomp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        o_strobe;
    logic signed [31:0] o_temperature_centi;
    logic signed [31:0] o_fine_temperature;
    logic [31:0] o_pressure_q24_8;
    logic        o_pressure_invalid;

    baro_temp_pressure_compensation i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_raw_temperature(i_raw_temperature), .i_raw_pressure(i_raw_pressure),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_temperature_centi(o_temperature_centi),
        .o_fine_temperature(o_fine_temperature), .o_pressure_q24_8(o_pressure_q24_8),
        .o_pressure_invalid(o_pressure_invalid)
    );

    always #5 i_clk = ~i_clk;

    logic [47:0] cf_temp;
    logic [63:0] cf_pa;
    logic [63:0] cf_pb;
    logic [15:0] cf_p9;

    t_reading pending_q[$];
    int errors = 0;
    int n_words = 0;
    int n_results = 0;
    int n_invalid = 0;
    int n_cfg = 0;
    int stall_cnt = 0;
    bit quiet = 0;

    function automatic logic [31:0] asr32(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_reading compensate(logic [19:0] rt, logic [19:0] rp);
        logic [31:0] adt, t1, t2, t3, x, a, d, b, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, ps, w1, w2, num, mn, md, q;
        t_reading r;
        adt = {12'd0, rt};
        t1 = {16'd0, cf_temp[15:0]};
        t2 = {{16{cf_temp[31]}}, cf_temp[31:16]};
        t3 = {{16{cf_temp[47]}}, cf_temp[47:32]};
        x = (adt >> 3) - (t1 << 1);
        x = x * t2;
        a = asr32(x, 11);
        d = (adt >> 4) - t1;
        x = d * d;
        x = asr32(x, 12);
        x = x * t3;
        b = asr32(x, 14);
        fine = a + b;
        x = fine * 32'd5 + 32'd128;
        r.tc = asr32(x, 8);
        r.fine = fine;

        p1 = {48'd0, cf_pa[15:0]};
        p2 = sx16(cf_pa[31:16]);
        p3 = sx16(cf_pa[47:32]);
        p4 = sx16(cf_pa[63:48]);
        p5 = sx16(cf_pb[15:0]);
        p6 = sx16(cf_pb[31:16]);
        p7 = sx16(cf_pb[47:32]);
        p8 = sx16(cf_pb[63:48]);
        p9 = sx16(cf_p9);
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        r.press = '0;
        r.inv = 1'b0;
        if (v1 == 64'd0) begin
            r.inv = 1'b1;
        end else begin
            p = 64'd1048576 - {44'd0, rp};
            num = ((p << 31) - v2) * 64'd3125;
            mn = num[63] ? 64'd0 - num : num;
            md = v1[63] ? 64'd0 - v1 : v1;
            q = mn / md;
            p = (num[63] != v1[63]) ? 64'd0 - q : q;
            ps = asr64(p, 13);
            w1 = asr64(p9 * ps * ps, 25);
            w2 = asr64(p8 * p, 19);
            p = asr64(p + w1 + w2, 8) + (p7 << 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $time);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (o_pressure_invalid) n_invalid++;
            if (pending_q.size() == 0) begin
                $display("unexpected result word at %0t", $time);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_temperature_centi !== e.tc)
                    report_mismatch("temperature_centi", e.tc, o_temperature_centi);
                if (o_fine_temperature !== e.fine)
                    report_mismatch("fine_temperature", e.fine, o_fine_temperature);
                if (o_pressure_q24_8 !== e.press)
                    report_mismatch("pressure_q24_8", e.press, o_pressure_q24_8);
                if (o_pressure_invalid !== e.inv)
                    report_mismatch("pressure_invalid", e.inv, o_pressure_invalid);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic maybe_idle();
        if (!quiet && $urandom_range(99) < 32) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_word(logic [19:0] rt, logic [19:0] rp, bit typed, t_reading want);
        start <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(typed ? want : compensate(rt, rp));
        n_words++;
        maybe_idle();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [bcomp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bcomp_pkg::CFG_TEMP_COEFFS: cf_temp = data[47:0];
            bcomp_pkg::CFG_PRESS_A:     cf_pa = data;
            bcomp_pkg::CFG_PRESS_B:     cf_pb = data;
            bcomp_pkg::CFG_PRESS_LAST:  cf_p9 = data[15:0];
            default: ;
        endcase
        n_cfg++;
        if (!quiet && $urandom_range(99) < 32) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_coeffs(logic [63:0] t, logic [63:0] a, logic [63:0] b, logic [63:0] l);
        drain();
        cfg_write(bcomp_pkg::CFG_TEMP_COEFFS, t);
        cfg_write(bcomp_pkg::CFG_PRESS_A, a);
        cfg_write(bcomp_pkg::CFG_PRESS_B, b);
        cfg_write(bcomp_pkg::CFG_PRESS_LAST, l);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_words(int count);
        logic [19:0] rt, rp;
        int pick;
        t_reading none;
        none = '{default: '0};
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                rt = 20'($urandom_range(400000, 600000));
                rp = 20'($urandom_range(250000, 500000));
            end else if (pick < 90) begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end else begin
                rt = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
                rp = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
            end
            send_word(rt, rp, 1'b0, none);
        end
    endtask

    // typical factory coefficients
    localparam logic [63:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_L = 64'd6000;

    t_row rows[N_ROWS];
    t_reading all_zero;

    initial begin
        all_zero = '{tc: 0, fine: 0, press: 0, inv: 1'b1};
        // coefficients at reset: everything collapses to zero, divisor zero
        rows[0]  = '{20'h00000, 20'h00000, 1'b1, all_zero};
        rows[1]  = '{20'hFFFFF, 20'hFFFFF, 1'b1, all_zero};
        rows[2]  = '{20'h00000, 20'hFFFFF, 1'b1, all_zero};
        rows[3]  = '{20'hFFFFF, 20'h00000, 1'b1, all_zero};
        rows[4]  = '{20'h80000, 20'h7FFFF, 1'b1, all_zero};
        rows[5]  = '{20'd519888, 20'd415148, 1'b1, all_zero};
        // typical coefficients
        rows[6]  = '{20'd519888, 20'd415148, 1'b0, all_zero};
        rows[7]  = '{20'h00000, 20'h00000, 1'b0, all_zero};
        rows[8]  = '{20'hFFFFF, 20'hFFFFF, 1'b0, all_zero};
        rows[9]  = '{20'h00000, 20'hFFFFF, 1'b0, all_zero};
        rows[10] = '{20'hFFFFF, 20'h00000, 1'b0, all_zero};
        rows[11] = '{20'd440064, 20'd330000, 1'b0, all_zero};
        rows[12] = '{20'h55555, 20'hAAAAA, 1'b0, all_zero};
        rows[13] = '{20'hAAAAA, 20'h55555, 1'b0, all_zero};

        cf_temp = '0; cf_pa = '0; cf_pb = '0; cf_p9 = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_raw_temperature <= '0;
        i_raw_pressure <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bcomp_pkg::CFG_TEMP_COEFFS;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (i == N_TYPED)
                load_coeffs(TYP_T, TYP_A, TYP_B, TYP_L);
            send_word(rows[i].rt, rows[i].rp, rows[i].typed, rows[i].want);
        end

        random_words(PHASE_WORDS);
        // typical set with P1 zero: divisor always zero
        load_coeffs(TYP_T, {TYP_A[63:16], 16'd0}, TYP_B, {48'hFFFF_FFFF_FFFF, 16'd6000});
        random_words(PHASE_WORDS / 2);
        load_coeffs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_words(PHASE_WORDS);
        load_coeffs({16'h0, 16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        random_words(PHASE_WORDS);
        load_coeffs({16'h0, 16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                    64'h8000_8000_8000_8000, 64'h8000);
        random_words(PHASE_WORDS);
        quiet = 1;
        load_coeffs(TYP_T, TYP_A, TYP_B, TYP_L);
        random_words(PHASE_WORDS);
        quiet = 0;
        repeat (3) begin
            load_coeffs({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
            random_words(PHASE_WORDS);
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("sent %0d words over %0d coefficient writes, checked %0d results",
                 n_words, n_cfg, n_results);
        $display("%0d results flagged a zero pressure divisor, %0d mismatches",
                 n_invalid, errors);
        if (errors == 0 && pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
